// ===== rtl/core/rce_pkg.sv =====
package rce_pkg;

    // Default sizes of the machine.
    localparam int ALPHABET_MAX_DEF   = 64;
    localparam int ROTOR_BANK_DEF     = 16;
    localparam int REFLECTOR_BANK_DEF = 16;
    localparam int SLOTS_MAX_DEF      = 8;

    // Widest table address and entry over the supported parameter ranges.
    localparam int MEM_AW = 14;
    localparam int MEM_DW = 8;

    // Item actions.
    localparam logic [2:0] ACT_WIRE   = 3'd0;
    localparam logic [2:0] ACT_REFL   = 3'd1;
    localparam logic [2:0] ACT_NOTCH  = 3'd2;
    localparam logic [2:0] ACT_SET    = 3'd3;
    localparam logic [2:0] ACT_ENC    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALPHABET  = 2'd0;
    localparam logic [1:0] CFG_ROTORS    = 2'd1;
    localparam logic [1:0] CFG_REFLECTOR = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] table_index;
        logic [2:0] slot;
        logic [6:0] letter;
        logic [6:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [6:0] cipher_symbol;
        logic       bad_symbol;
    } t_out;

    typedef enum logic [1:0] {
        MSEL_FWD,
        MSEL_INV,
        MSEL_REFL,
        MSEL_NOTCH
    } t_msel;

    typedef struct packed {
        logic              wire_we;
        logic              refl_we;
        logic              notch_we;
        logic [MEM_AW-1:0] addr_a;
        logic [MEM_AW-1:0] addr_b;
        logic [MEM_DW-1:0] data_a;
        logic [MEM_DW-1:0] data_b;
        logic              notch_bit;
    } t_mem_wr;

    typedef struct packed {
        t_msel             sel;
        logic [MEM_AW-1:0] addr;
    } t_mem_rd;

endpackage

// ===== rtl/core/rce_tables.sv =====
module rce_tables #(
    parameter int ALPHABET_MAX   = rce_pkg::ALPHABET_MAX_DEF,
    parameter int ROTOR_BANK     = rce_pkg::ROTOR_BANK_DEF,
    parameter int REFLECTOR_BANK = rce_pkg::REFLECTOR_BANK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rce_pkg::t_mem_wr                i_wr,
    input  rce_pkg::t_mem_rd                i_rd,
    output logic [$clog2(ALPHABET_MAX)-1:0] o_rd_data,
    output logic                            o_notch,
    output logic                            o_clearing
);
    import rce_pkg::*;

    localparam int PW  = $clog2(ALPHABET_MAX);
    localparam int ND  = ROTOR_BANK * ALPHABET_MAX;
    localparam int FD  = REFLECTOR_BANK * ALPHABET_MAX;
    localparam int RAW = $clog2(ND);
    localparam int FAW = $clog2(FD);

    logic [PW-1:0] fwd_mem   [ND];
    logic [PW-1:0] inv_mem   [ND];
    logic [PW-1:0] refl_mem  [FD];
    logic          notch_mem [ND];

    logic [PW-1:0]  r_fwd_q;
    logic [PW-1:0]  r_inv_q;
    logic [PW-1:0]  r_refl_q;
    logic           r_notch_q;
    t_msel          r_sel;
    logic           r_clearing;
    logic [RAW-1:0] r_clr_cnt;

    logic [RAW-1:0] notch_wa;
    logic           notch_we;
    logic           notch_wd;

    always_comb begin
        notch_wa = r_clearing ? r_clr_cnt : i_wr.addr_a[RAW-1:0];
        notch_we = r_clearing | i_wr.notch_we;
        notch_wd = r_clearing ? 1'b0 : i_wr.notch_bit;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wire_we) begin
            fwd_mem[i_wr.addr_a[RAW-1:0]] <= i_wr.data_a[PW-1:0];
            inv_mem[i_wr.addr_b[RAW-1:0]] <= i_wr.data_b[PW-1:0];
        end
        if (i_wr.refl_we) begin
            refl_mem[i_wr.addr_a[FAW-1:0]] <= i_wr.data_a[PW-1:0];
        end
        if (notch_we) begin
            notch_mem[notch_wa] <= notch_wd;
        end
        r_fwd_q   <= fwd_mem[i_rd.addr[RAW-1:0]];
        r_inv_q   <= inv_mem[i_rd.addr[RAW-1:0]];
        r_refl_q  <= refl_mem[i_rd.addr[FAW-1:0]];
        r_notch_q <= notch_mem[i_rd.addr[RAW-1:0]];
        r_sel     <= i_rd.sel;
    end

    // The notch table clears itself once after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == RAW'(ND - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_comb begin
        case (r_sel)
            MSEL_FWD:  o_rd_data = r_fwd_q;
            MSEL_INV:  o_rd_data = r_inv_q;
            MSEL_REFL: o_rd_data = r_refl_q;
            default:   o_rd_data = '0;
        endcase
    end

    assign o_notch    = r_notch_q;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/core/rce_ctrl.sv =====
module rce_ctrl #(
    parameter int ALPHABET_MAX   = rce_pkg::ALPHABET_MAX_DEF,
    parameter int REFLECTOR_BANK = rce_pkg::REFLECTOR_BANK_DEF,
    parameter int ROTOR_BANK     = rce_pkg::ROTOR_BANK_DEF,
    parameter int SLOTS_MAX      = rce_pkg::SLOTS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  rce_pkg::t_in                    i_item,
    input  logic [7:0]                      i_n,
    input  logic [$clog2(SLOTS_MAX+1)-1:0]  i_k,
    input  logic [3:0]                      i_refl_sel,
    output rce_pkg::t_mem_wr                o_wr,
    output rce_pkg::t_mem_rd                o_rd,
    input  logic [$clog2(ALPHABET_MAX)-1:0] i_rd_data,
    input  logic                            i_notch,
    output logic                            o_busy,
    output logic                            o_strobe,
    output rce_pkg::t_out                   o_result
);
    import rce_pkg::*;

    localparam int PW   = $clog2(ALPHABET_MAX);
    localparam int VW   = (PW > 8) ? PW : 8;
    localparam int JW   = $clog2(SLOTS_MAX + 1);
    localparam int SW   = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
    localparam int IDX1 = (SLOTS_MAX > 1) ? 1 : 0;
    localparam logic [MEM_AW-1:0] AM_A = MEM_AW'(ALPHABET_MAX);
    localparam logic [VW:0]       AM_V = (VW+1)'(ALPHABET_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_SETRED, S_POSRED, S_N0, S_N1, S_N2, S_RMOD, S_RD, S_WT, S_RED
    } t_state;

    typedef enum logic [1:0] {
        PH_FWD, PH_REF, PH_BWD
    } t_phase;

    t_state        r_state;
    t_phase        r_ph;
    logic [JW-1:0] r_j;
    logic [SW-1:0] r_slot;
    logic [3:0]    r_tab;
    logic [VW:0]   r_v;
    logic [VW-1:0] r_x;
    logic [VW-1:0] r_y;
    logic [3:0]    r_refl;
    logic          r_nt0;
    logic          r_first;
    logic          r_second;
    logic [PW-1:0] r_pos [SLOTS_MAX];
    logic [PW-1:0] r_t   [SLOTS_MAX];
    logic [3:0]    r_rot [SLOTS_MAX];
    logic          r_strobe;
    t_out          r_result;

    logic [SW-1:0] jx;
    logic [VW-1:0] n;
    logic [VW-1:0] cur_t;
    logic [VW:0]   sum;
    logic [VW-1:0] idx;
    logic [VW-1:0] d;
    logic          fin;
    logic [VW-1:0] fin_y;
    logic [VW-1:0] x_new;
    logic [VW-1:0] p0;
    logic [VW-1:0] p1;
    logic [VW-1:0] nxt0;
    logic [VW-1:0] nxt1;
    logic [VW-1:0] nxt2;
    logic          ok_entry;
    logic          ok_val;
    logic          ok_rotor;
    logic          ok_refl;
    logic          bad_letter;

    // r_pos holds the stored positions; r_t is the working copy of one
    // encipher beat, reduced below the alphabet size.
    always_comb begin
        jx    = r_j[SW-1:0];
        n     = VW'(i_n);
        cur_t = VW'(r_t[jx]);
        sum   = {1'b0, r_x} + {1'b0, cur_t};
        idx   = (sum >= {1'b0, n}) ? VW'(sum - {1'b0, n}) : VW'(sum);
        d     = VW'(i_rd_data);
        if (r_state == S_WT) begin
            fin   = (d < n);
            fin_y = d;
        end else begin
            fin   = (r_state == S_RED) && (r_y < n);
            fin_y = r_y;
        end
        x_new = (fin_y >= cur_t) ? (fin_y - cur_t) : (fin_y + n - cur_t);
        p0    = VW'(r_t[0]);
        p1    = VW'(r_t[IDX1]);
        nxt0  = (p0 + 1'b1 == n) ? '0 : p0 + 1'b1;
        nxt1  = (p1 + 1'b1 == n) ? '0 : p1 + 1'b1;
        nxt2  = (VW'(r_t[SW'(2)]) + 1'b1 == n) ? '0 : VW'(r_t[SW'(2)]) + 1'b1;
    end

    // Write port: table loads go straight to the memories on the accepting edge.
    always_comb begin
        ok_entry   = (i_item.letter != 7'd0) && ({1'b0, VW'(i_item.letter)} <= AM_V);
        ok_val     = (i_item.entry_value != 7'd0) &&
                     ({1'b0, VW'(i_item.entry_value)} <= AM_V);
        ok_rotor   = (7'(i_item.table_index) < 7'(ROTOR_BANK));
        ok_refl    = (7'(i_item.table_index) < 7'(REFLECTOR_BANK));
        bad_letter = (i_item.letter == 7'd0) || (VW'(i_item.letter) > n);

        o_wr           = '0;
        o_wr.wire_we   = i_accept && (i_item.action == ACT_WIRE) && ok_rotor &&
                         ok_entry && ok_val;
        o_wr.refl_we   = i_accept && (i_item.action == ACT_REFL) && ok_refl &&
                         ok_entry && ok_val;
        o_wr.notch_we  = i_accept && (i_item.action == ACT_NOTCH) && ok_rotor && ok_entry;
        o_wr.addr_a    = MEM_AW'(i_item.table_index) * AM_A +
                         MEM_AW'(i_item.letter) - 1'b1;
        o_wr.addr_b    = MEM_AW'(i_item.table_index) * AM_A +
                         MEM_AW'(i_item.entry_value) - 1'b1;
        o_wr.data_a    = MEM_DW'(i_item.entry_value - 7'd1);
        o_wr.data_b    = MEM_DW'(i_item.letter - 7'd1);
        o_wr.notch_bit = (i_item.entry_value != 7'd0);
    end

    always_comb begin
        o_rd.sel  = MSEL_FWD;
        o_rd.addr = '0;
        case (r_state)
            S_N0: begin
                o_rd.sel  = MSEL_NOTCH;
                o_rd.addr = MEM_AW'(r_rot[0]) * AM_A + MEM_AW'(nxt0);
            end
            S_N1: begin
                o_rd.sel  = MSEL_NOTCH;
                o_rd.addr = MEM_AW'(r_rot[IDX1]) * AM_A + MEM_AW'(nxt1);
            end
            S_RD: begin
                case (r_ph)
                    PH_REF: begin
                        o_rd.sel  = MSEL_REFL;
                        o_rd.addr = MEM_AW'(r_refl) * AM_A + MEM_AW'(r_x);
                    end
                    PH_BWD: begin
                        o_rd.sel  = MSEL_INV;
                        o_rd.addr = MEM_AW'(r_rot[jx]) * AM_A + MEM_AW'(idx);
                    end
                    default: begin
                        o_rd.sel  = MSEL_FWD;
                        o_rd.addr = MEM_AW'(r_rot[jx]) * AM_A + MEM_AW'(idx);
                    end
                endcase
            end
            default: begin
                o_rd.sel  = MSEL_FWD;
                o_rd.addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= PH_FWD;
            r_j      <= '0;
            r_first  <= 1'b0;
            r_second <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < SLOTS_MAX; i++) begin
                r_pos[i] <= '0;
                r_rot[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_accept && (i_item.action == ACT_SET) &&
                        (5'(i_item.slot) < 5'(SLOTS_MAX)) && ok_rotor) begin
                        r_slot  <= SW'(i_item.slot);
                        r_tab   <= i_item.table_index;
                        r_v     <= (i_item.letter == 7'd0) ? AM_V - 1'b1 :
                                   (VW+1)'(i_item.letter - 7'd1);
                        r_state <= S_SETRED;
                    end else if (i_accept && (i_item.action == ACT_ENC)) begin
                        if (bad_letter) begin
                            r_strobe                <= 1'b1;
                            r_result.cipher_symbol  <= 7'd0;
                            r_result.bad_symbol     <= 1'b1;
                        end else begin
                            r_x     <= VW'(i_item.letter - 7'd1);
                            r_refl  <= i_refl_sel;
                            r_j     <= '0;
                            for (int i = 0; i < SLOTS_MAX; i++) begin
                                r_t[i] <= r_pos[i];
                            end
                            r_state <= S_POSRED;
                        end
                    end
                end
                S_SETRED: begin
                    if (r_v >= AM_V) begin
                        r_v <= r_v - AM_V;
                    end else begin
                        r_pos[r_slot] <= r_v[PW-1:0];
                        r_rot[r_slot] <= r_tab;
                        r_first       <= 1'b0;
                        r_second      <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                S_POSRED: begin
                    // Bring the working copy of every position in use below
                    // the alphabet size; the stored positions stay as they are.
                    if (r_j == i_k) begin
                        r_state <= S_N0;
                    end else if (cur_t >= n) begin
                        r_t[jx] <= PW'(cur_t - n);
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_N0: begin
                    r_state <= S_N1;
                end
                S_N1: begin
                    r_nt0   <= i_notch;
                    r_state <= S_N2;
                end
                S_N2: begin
                    r_pos[0] <= PW'(nxt0);
                    r_t[0]   <= PW'(nxt0);
                    if ((i_k > JW'(2)) && i_notch && r_second) begin
                        r_pos[IDX1]   <= PW'(nxt1);
                        r_t[IDX1]     <= PW'(nxt1);
                        r_pos[SW'(2)] <= PW'(nxt2);
                        r_t[SW'(2)]   <= PW'(nxt2);
                    end else if ((i_k > JW'(1)) && r_nt0 && r_first) begin
                        r_pos[IDX1] <= PW'(nxt1);
                        r_t[IDX1]   <= PW'(nxt1);
                        r_second    <= 1'b1;
                    end else begin
                        r_first <= 1'b1;
                    end
                    r_j     <= '0;
                    r_ph    <= PH_FWD;
                    r_state <= S_RD;
                end
                S_RMOD: begin
                    if (5'(r_refl) >= 5'(REFLECTOR_BANK)) begin
                        r_refl <= 4'(5'(r_refl) - 5'(REFLECTOR_BANK));
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WT;
                end
                S_WT, S_RED: begin
                    if (!fin) begin
                        r_y     <= ((r_state == S_WT) ? d : r_y) - n;
                        r_state <= S_RED;
                    end else begin
                        case (r_ph)
                            PH_REF: begin
                                r_x     <= fin_y;
                                r_ph    <= PH_BWD;
                                r_j     <= i_k - 1'b1;
                                r_state <= S_RD;
                            end
                            PH_FWD: begin
                                r_x <= x_new;
                                if (r_j == i_k - 1'b1) begin
                                    r_ph    <= PH_REF;
                                    r_state <= S_RMOD;
                                end else begin
                                    r_j     <= r_j + 1'b1;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (r_j == '0) begin
                                    r_strobe               <= 1'b1;
                                    r_result.cipher_symbol <= 7'(x_new + 1'b1);
                                    r_result.bad_symbol    <= 1'b0;
                                    r_state                <= S_IDLE;
                                end else begin
                                    r_x     <= x_new;
                                    r_j     <= r_j - 1'b1;
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/core/rotor_cipher_engine_unit.sv =====
// Rotor cipher engine: a generalized rotor machine over an alphabet of up to
// ALPHABET_MAX symbols. Wiring, reflector and notch tables live in on-chip
// memories with a registered read; the sequencer looks them up one
// entry at a time. A beat is accepted when start is high and busy is low.
// Table loads finish in the accepting cycle, so busy never rises for them.
// A set-slot beat keeps busy high while it brings its start position below
// ALPHABET_MAX. An encipher beat with k slots in use goes through the
// accepting cycle, bringing the start positions into range one slot at a
// time, the two notch reads, folding the reflector index, and a registered
// memory read for each of the 2k + 1 lookups through the rotors and
// reflector. A table entry or start position that is not below the alphabet
// size is brought into range by repeated subtraction, which keeps busy high
// longer. A rejected symbol returns its beat in the cycle after it is taken.
// Each result appears on o_result with o_strobe high for exactly one cycle;
// the receiver cannot stall it, so capture it on that edge. After reset the
// notch table clears itself, which keeps busy high until it is done;
// configuration writes are taken at any time and o_cfg_ready stays high.
module rotor_cipher_engine_unit #(
    parameter int ALPHABET_MAX   = rce_pkg::ALPHABET_MAX_DEF,
    parameter int ROTOR_BANK     = rce_pkg::ROTOR_BANK_DEF,
    parameter int REFLECTOR_BANK = rce_pkg::REFLECTOR_BANK_DEF,
    parameter int SLOTS_MAX      = rce_pkg::SLOTS_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rce_pkg::t_in  i_item,
    output logic          o_strobe,
    output rce_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [6:0]    i_cfg_data
);
    import rce_pkg::*;

    localparam int PW = $clog2(ALPHABET_MAX);
    localparam int JW = $clog2(SLOTS_MAX + 1);

    logic [6:0] r_alpha;
    logic [3:0] r_rotors;
    logic [3:0] r_refl_sel;

    logic          accept;
    logic          ctrl_busy;
    logic          clearing;
    logic [7:0]    n_eff;
    logic [JW-1:0] k_eff;
    t_mem_wr       wr;
    t_mem_rd       rd;
    logic [PW-1:0] rd_data;
    logic          notch;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= 7'd26;
            r_rotors   <= 4'd3;
            r_refl_sel <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHABET:  r_alpha    <= i_cfg_data;
                CFG_ROTORS:    r_rotors   <= i_cfg_data[3:0];
                CFG_REFLECTOR: r_refl_sel <= i_cfg_data[3:0];
                default:       r_alpha    <= r_alpha;
            endcase
        end
    end

    // A zero alphabet or slot count acts as one; larger values saturate.
    always_comb begin
        if (r_alpha == 7'd0) begin
            n_eff = 8'd1;
        end else if (9'(r_alpha) > 9'(ALPHABET_MAX)) begin
            n_eff = 8'(ALPHABET_MAX);
        end else begin
            n_eff = 8'(r_alpha);
        end
        if (r_rotors == 4'd0) begin
            k_eff = JW'(1);
        end else if (5'(r_rotors) > 5'(SLOTS_MAX)) begin
            k_eff = JW'(SLOTS_MAX);
        end else begin
            k_eff = JW'(r_rotors);
        end
    end

    assign busy        = ctrl_busy | clearing;
    assign accept      = start & ~busy;
    assign o_cfg_ready = 1'b1;

    rce_tables #(
        .ALPHABET_MAX   (ALPHABET_MAX),
        .ROTOR_BANK     (ROTOR_BANK),
        .REFLECTOR_BANK (REFLECTOR_BANK)
    ) u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd       (rd),
        .o_rd_data  (rd_data),
        .o_notch    (notch),
        .o_clearing (clearing)
    );

    rce_ctrl #(
        .ALPHABET_MAX   (ALPHABET_MAX),
        .REFLECTOR_BANK (REFLECTOR_BANK),
        .ROTOR_BANK     (ROTOR_BANK),
        .SLOTS_MAX      (SLOTS_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_n        (n_eff),
        .i_k        (k_eff),
        .i_refl_sel (r_refl_sel),
        .o_wr       (wr),
        .o_rd       (rd),
        .i_rd_data  (rd_data),
        .i_notch    (notch),
        .o_busy     (ctrl_busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
